// ----- rtl/core/adc_wet_pkg.sv -----
// Shared widths, register indexes and constants for the averaged ADC
// wetness reader. No dependencies.
package adc_wet_pkg;

  localparam int AdcW     = 12;
  localparam int SumW     = 20;
  localparam int CntW     = 8;
  localparam int PctW     = 7;
  localparam int RemW     = AdcW + 1;
  localparam int PctDvdW  = AdcW + PctW;
  localparam int StepW    = 5;
  localparam int CfgIdxW  = 2;

  localparam int unsigned Hundred = 100;

  localparam logic [CfgIdxW-1:0] RegSamples = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDry     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWet     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPinLow  = 2'd3;

  localparam logic [CntW-1:0] SamplesReset = 8'd8;
  localparam logic [AdcW-1:0] DryReset     = {AdcW{1'b1}};
  localparam logic [AdcW-1:0] WetReset     = '0;

endpackage

// ----- rtl/core/averaged_adc_wetness_percent_top.sv -----
// Averaged ADC wetness reader: bit-serial accumulator and shared
// bit-serial restoring divider. Depends on adc_wet_pkg.

// An item that does not complete a reading is accepted and then added
// bit-serially into the running sum. The item that completes a reading
// goes on from the add to the shared restoring divider for the average,
// then calibration setup (S_CAL, S_LOAD), the divider again for the
// rounded percent, and the load of the output register, which waits
// until that register is free. When the average lies at or beyond a
// calibration point the percent division is skipped. The add and the
// divider work one bit per cycle. A finished result waits in the output
// register while the next item is accepted.
module averaged_adc_wetness_percent_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [adc_wet_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [adc_wet_pkg::AdcW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [adc_wet_pkg::AdcW-1:0]     adc_sample_i,
  input  logic                             pin_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adc_wet_pkg::AdcW-1:0]     average_o,
  output logic [adc_wet_pkg::PctW-1:0]     wet_percent_o,
  output logic                             wet_flag_o
);

  localparam int AdcW    = adc_wet_pkg::AdcW;
  localparam int SumW    = adc_wet_pkg::SumW;
  localparam int CntW    = adc_wet_pkg::CntW;
  localparam int PctW    = adc_wet_pkg::PctW;
  localparam int RemW    = adc_wet_pkg::RemW;
  localparam int PctDvdW = adc_wet_pkg::PctDvdW;
  localparam int StepW   = adc_wet_pkg::StepW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_CAL  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIVP = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_q;
  logic [CntW-1:0]  spr_q;
  logic [AdcW-1:0]  dry_q, wet_q;
  logic             pin_low_q;

  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  index_q;
  logic [AdcW-1:0]  samp_q;
  logic             pin_q;
  logic             carry_q;
  logic [StepW-1:0] step_q;

  logic [RemW-1:0]  rem_q;
  logic [AdcW-1:0]  dvd_q;
  logic [AdcW-1:0]  dvs_q;
  logic [AdcW-1:0]  num_q;
  logic [AdcW-1:0]  avg_q;
  logic [PctW-1:0]  pct_q;

  logic             out_valid_q;
  logic [AdcW-1:0]  avg_out_q;
  logic [PctW-1:0]  pct_out_q;
  logic             flag_out_q;

  logic             add_a, add_b, add_s, add_c;
  logic [RemW-1:0]  rem_sh, rem_d;
  logic [AdcW-1:0]  dvd_d;
  logic             q_bit;
  logic [CntW-1:0]  taken, target;
  logic [PctDvdW-1:0] dividend;
  logic             out_free;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign average_o     = avg_out_q;
  assign wet_percent_o = pct_out_q;
  assign wet_flag_o    = flag_out_q;
  assign out_free      = !out_valid_q || out_ready_i;

  assign add_a = samp_q[0];
  assign add_b = sum_q[0];
  assign add_s = add_a ^ add_b ^ carry_q;
  assign add_c = (add_a & add_b) | (carry_q & (add_a ^ add_b));

  assign taken  = index_q + CntW'(1);
  assign target = (spr_q == '0) ? CntW'(1) : spr_q;

  always_comb begin
    rem_sh = {rem_q[AdcW-1:0], dvd_q[AdcW-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_q});
    rem_d  = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    dvd_d  = {dvd_q[AdcW-2:0], q_bit};
  end

  assign dividend = PctDvdW'(num_q) * PctDvdW'(adc_wet_pkg::Hundred)
                  + PctDvdW'(dvs_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q     <= adc_wet_pkg::SamplesReset;
      dry_q     <= adc_wet_pkg::DryReset;
      wet_q     <= adc_wet_pkg::WetReset;
      pin_low_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        adc_wet_pkg::RegSamples: spr_q     <= cfg_data_i[CntW-1:0];
        adc_wet_pkg::RegDry:     dry_q     <= cfg_data_i;
        adc_wet_pkg::RegWet:     wet_q     <= cfg_data_i;
        adc_wet_pkg::RegPinLow:  pin_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      index_q     <= '0;
      step_q      <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            samp_q  <= adc_sample_i;
            pin_q   <= pin_level_i;
            carry_q <= 1'b0;
            step_q  <= '0;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          sum_q   <= {add_s, sum_q[SumW-1:1]};
          carry_q <= add_c;
          samp_q  <= {1'b0, samp_q[AdcW-1:1]};
          if (step_q == StepW'(SumW - 1)) begin
            if (taken < target) begin
              index_q <= taken;
              state_q <= S_IDLE;
            end else begin
              dvs_q   <= AdcW'(taken);
              rem_q   <= RemW'({add_s, sum_q[SumW-1:AdcW+1]});
              dvd_q   <= sum_q[AdcW:1];
              step_q  <= '0;
              state_q <= S_DIVA;
            end
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        S_DIVA: begin
          rem_q  <= rem_d;
          dvd_q  <= dvd_d;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(AdcW - 1)) begin
            avg_q   <= dvd_d;
            state_q <= S_CAL;
          end
        end
        S_CAL: begin
          state_q <= S_LOAD;
          if (dry_q > wet_q) begin
            num_q <= dry_q - avg_q;
            dvs_q <= dry_q - wet_q;
            if (avg_q >= dry_q) begin
              pct_q   <= '0;
              state_q <= S_DONE;
            end else if (avg_q <= wet_q) begin
              pct_q   <= PctW'(adc_wet_pkg::Hundred);
              state_q <= S_DONE;
            end
          end else begin
            num_q <= avg_q - dry_q;
            dvs_q <= wet_q - dry_q;
            if (avg_q <= dry_q) begin
              pct_q   <= '0;
              state_q <= S_DONE;
            end else if (avg_q >= wet_q) begin
              pct_q   <= PctW'(adc_wet_pkg::Hundred);
              state_q <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          rem_q   <= RemW'(dividend[PctDvdW-1:PctW]);
          dvd_q   <= {dividend[PctW-1:0], {(AdcW-PctW){1'b0}}};
          step_q  <= '0;
          state_q <= S_DIVP;
        end
        S_DIVP: begin
          rem_q  <= rem_d;
          dvd_q  <= dvd_d;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(PctW - 1)) begin
            pct_q   <= dvd_d[PctW-1:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            avg_out_q   <= avg_q;
            pct_out_q   <= pct_q;
            flag_out_q  <= pin_low_q ? !pin_q : pin_q;
            out_valid_q <= 1'b1;
            sum_q       <= '0;
            index_q     <= '0;
            state_q     <= S_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for averaged_adc_wetness_percent_top: a directed table, then random
// phases; each reading checked by a predictor or its typed row. Uses adc_wet_pkg.
module testbench;

  localparam int AdcW         = adc_wet_pkg::AdcW;
  localparam int PctW         = adc_wet_pkg::PctW;
  localparam int CntW         = adc_wet_pkg::CntW;
  localparam int SumW         = adc_wet_pkg::SumW;
  localparam int CfgIdxW      = adc_wet_pkg::CfgIdxW;
  localparam int HalfPeriod   = 6;
  localparam int SettleCycles = 64;
  localparam int HoldCycles   = 600;
  localparam int StallLimit   = 4000;
  localparam int NumPhases    = 9;
  localparam int BigPhase     = 4;
  localparam int HoldPhase    = 6;
  localparam int AdcMax       = (1 << AdcW) - 1;

  typedef struct packed {
    logic [AdcW-1:0] average;
    logic [PctW-1:0] percent;
    logic            wet;
  } reading_t;

  typedef enum logic [1:0] {RowCfg, RowItem, RowTyped} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  index;
    logic [AdcW-1:0]     value;
    logic                pin;
    reading_t            want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AdcW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [AdcW-1:0]    adc_sample_i;
  logic               pin_level_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [AdcW-1:0]    average_o;
  logic [PctW-1:0]    wet_percent_o;
  logic               wet_flag_o;

  logic [CntW-1:0]    cfg_samples = adc_wet_pkg::SamplesReset;
  logic [AdcW-1:0]    cfg_dry     = adc_wet_pkg::DryReset;
  logic [AdcW-1:0]    cfg_wet     = adc_wet_pkg::WetReset;
  logic               cfg_pin_low = 1'b1;
  logic [SumW-1:0]    run_sum     = '0;
  logic [CntW-1:0]    run_count   = '0;
  reading_t           pending_readings[$];

  bit                 typed_pending = 1'b0;
  reading_t           typed_want    = '0;
  bit                 hold_toggle   = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 mismatches    = 0;
  int                 readings_checked = 0;
  int                 writes_done   = 0;
  int                 items_taken   = 0;
  int                 stall_cycles  = 0;

  averaged_adc_wetness_percent_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sample_i  (adc_sample_i),
    .pin_level_i   (pin_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .wet_percent_o (wet_percent_o),
    .wet_flag_o    (wet_flag_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  function automatic logic [PctW-1:0] calibrated_percent(input logic [AdcW-1:0] raw);
    int unsigned num;
    int unsigned den;
    num = 0;
    den = 1;
    if (cfg_dry > cfg_wet) begin
      if (raw >= cfg_dry) return '0;
      else if (raw <= cfg_wet) return PctW'(adc_wet_pkg::Hundred);
      num = cfg_dry - raw;
      den = cfg_dry - cfg_wet;
    end else begin
      if (raw <= cfg_dry) return '0;
      else if (raw >= cfg_wet) return PctW'(adc_wet_pkg::Hundred);
      num = raw - cfg_dry;
      den = cfg_wet - cfg_dry;
    end
    return PctW'((num * adc_wet_pkg::Hundred + den / 2) / den);
  endfunction

  task automatic accumulate_sample(input logic [AdcW-1:0] sample, input logic pin,
                                   output bit done, output reading_t r);
    int unsigned     target;
    int unsigned     taken;
    logic [SumW-1:0] avg;
    target = (cfg_samples == '0) ? 1 : cfg_samples;
    run_sum = run_sum + sample;
    taken = run_count + 1;
    done = 1'b0;
    r = '0;
    if (taken < target) begin
      run_count = taken[CntW-1:0];
    end else begin
      avg = SumW'(run_sum / taken);
      r.average = avg[AdcW-1:0];
      r.percent = calibrated_percent(r.average);
      r.wet = cfg_pin_low ? !pin : pin;
      done = 1'b1;
      run_sum = '0;
      run_count = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch in %s: got %0d, expected %0d (after %0d readings)",
             what, got, want, readings_checked);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    reading_t want;
    bit       done;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result with no reading pending", average_o, 0);
        end else begin
          want = pending_readings.pop_front();
          if (average_o !== want.average)
            report_mismatch("average", average_o, want.average);
          if (wet_percent_o !== want.percent)
            report_mismatch("wet_percent", wet_percent_o, want.percent);
          if (wet_flag_o !== want.wet)
            report_mismatch("wet_flag", wet_flag_o, want.wet);
          readings_checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          adc_wet_pkg::RegSamples: cfg_samples = cfg_data_i[CntW-1:0];
          adc_wet_pkg::RegDry:     cfg_dry = cfg_data_i;
          adc_wet_pkg::RegWet:     cfg_wet = cfg_data_i;
          adc_wet_pkg::RegPinLow:  cfg_pin_low = cfg_data_i[0];
        endcase
        writes_done++;
      end
      if (in_valid_i && in_ready_o) begin
        accumulate_sample(adc_sample_i, pin_level_i, done, want);
        if (done) pending_readings.push_back(typed_pending ? typed_want : want);
        items_taken++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold off for a long stretch whenever the stimulus flips hold_toggle
  initial begin : result_sink
    int hold_left;
    bit seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [AdcW-1:0] sample, input logic pin,
                           input bit typed, input reading_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    typed_pending = typed;
    typed_want = want;
    in_valid_i <= 1'b1;
    adc_sample_i <= sample;
    pin_level_i <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [AdcW-1:0] value);
    drain_and_settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] index,
                                        input logic [AdcW-1:0] value);
    stim_row_t row;
    row = '{RowCfg, index, value, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic [AdcW-1:0] sample, input logic pin);
    stim_row_t row;
    row = '{RowItem, adc_wet_pkg::RegSamples, sample, pin, '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [AdcW-1:0] sample, input logic pin,
                                          input logic [AdcW-1:0] avg,
                                          input logic [PctW-1:0] pct, input logic wet);
    stim_row_t row;
    row = '{RowTyped, adc_wet_pkg::RegSamples, sample, pin, '{avg, pct, wet}};
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t       rows[$];
    reading_t        none;
    int unsigned     phase;
    int unsigned     n;
    int unsigned     k;
    int unsigned     spr;
    int unsigned     style;
    int              dry;
    int              wet;
    int              level;
    logic [AdcW-1:0] value;
    logic [AdcW-1:0] top;
    logic [PctW-1:0] full;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    adc_sample_i = '0;
    pin_level_i = 1'b0;
    none = '0;
    top = AdcW'(AdcMax);
    full = PctW'(adc_wet_pkg::Hundred);
    send_idle_pct = 6;
    recv_idle_pct = 86;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: eight samples per reading, dry at top, wet at zero
    repeat (7) rows.push_back(item_row(top, 1'b0));
    rows.push_back(typed_row(top, 1'b1, top, 0, 1'b0));
    // zero count acts as one
    rows.push_back(cfg_row(adc_wet_pkg::RegSamples, 0));
    rows.push_back(typed_row(0, 1'b0, 0, full, 1'b1));
    rows.push_back(typed_row(top, 1'b1, top, 0, 1'b0));
    rows.push_back(item_row(2048, 1'b0));
    rows.push_back(cfg_row(adc_wet_pkg::RegPinLow, 0));
    rows.push_back(typed_row(0, 1'b1, 0, full, 1'b1));
    // rising calibration order
    rows.push_back(cfg_row(adc_wet_pkg::RegDry, 0));
    rows.push_back(cfg_row(adc_wet_pkg::RegWet, top));
    rows.push_back(typed_row(0, 1'b0, 0, 0, 1'b0));
    rows.push_back(typed_row(top, 1'b1, top, full, 1'b1));
    rows.push_back(item_row(1234, 1'b1));
    // equal calibration points
    rows.push_back(cfg_row(adc_wet_pkg::RegDry, 2000));
    rows.push_back(cfg_row(adc_wet_pkg::RegWet, 2000));
    rows.push_back(typed_row(2000, 1'b0, 2000, 0, 1'b0));
    rows.push_back(typed_row(2001, 1'b1, 2001, full, 1'b1));
    rows.push_back(typed_row(1999, 1'b0, 1999, 0, 1'b0));
    // count lowered to the number of samples already taken
    rows.push_back(cfg_row(adc_wet_pkg::RegSamples, 4));
    rows.push_back(item_row(1000, 1'b0));
    rows.push_back(item_row(3000, 1'b1));
    rows.push_back(cfg_row(adc_wet_pkg::RegSamples, 2));
    rows.push_back(item_row(2000, 1'b0));

    foreach (rows[r]) begin
      case (rows[r].kind)
        RowCfg:   write_reg(rows[r].index, rows[r].value);
        RowItem:  send_item(rows[r].value, rows[r].pin, 1'b0, none);
        RowTyped: send_item(rows[r].value, rows[r].pin, 1'b1, rows[r].want);
      endcase
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      send_idle_pct = (phase < 3) ? 6 : (phase < 6) ? 86 : 0;
      recv_idle_pct = (phase < 3) ? 86 : (phase < 6) ? 6 : 0;

      spr = $urandom_range(0, 9);
      if ($urandom_range(3) == 0) spr = $urandom_range(10, 40);
      if (phase == BigPhase) spr = 255;
      if (phase == HoldPhase) spr = 1;
      dry = $urandom_range(0, AdcMax);
      wet = $urandom_range(0, AdcMax);
      style = $urandom_range(3);
      case (style)
        1: wet = dry;
        2: begin
          dry = $urandom_range(1) ? AdcMax : 0;
          wet = AdcMax - dry;
        end
        3: begin
          wet = dry + $urandom_range(0, 40) - 20;
          if (wet < 0) wet = 0;
          if (wet > AdcMax) wet = AdcMax;
        end
        default: ;
      endcase

      value = AdcW'(($urandom_range(15) << CntW) | spr);
      write_reg(adc_wet_pkg::RegSamples, value);
      write_reg(adc_wet_pkg::RegDry, AdcW'(dry));
      write_reg(adc_wet_pkg::RegWet, AdcW'(wet));
      value = AdcW'(($urandom_range(0, AdcMax) & ~1) | $urandom_range(1));
      write_reg(adc_wet_pkg::RegPinLow, value);

      n = (phase == BigPhase) ? 2 * 255 : 115;
      for (k = 0; k < n; k++) begin
        if (k == n / 2) begin
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (pending_readings.size() != 0);
        end
        if (phase == HoldPhase && k == 10) hold_toggle = !hold_toggle;
        style = $urandom_range(19);
        if (style < 14) begin
          level = $urandom_range(0, AdcMax);
        end else if (style < 17) begin
          level = ((style == 14) ? dry : wet) + $urandom_range(0, 60) - 30;
          if (level < 0) level = 0;
          if (level > AdcMax) level = AdcMax;
        end else begin
          level = (style == 17) ? 0 : AdcMax;
        end
        send_item(AdcW'(level), 1'($urandom_range(1)), 1'b0, none);
      end
    end

    drain_and_settle();
    $display("Ran %0d items through a directed table and %0d random phases;", items_taken,
             NumPhases);
    $display("checked %0d readings over %0d register writes, counts 0 to 255, both orders.",
             readings_checked, writes_done);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
